@@ design/lfba_pkg.sv @@
package lfba_pkg;

  localparam int NumBlocksDef = 1024;

  localparam int WordBits = 64;
  localparam int OffBits  = 6;

  localparam int OpW       = 3;
  localparam int InIdxW    = 10;
  localparam int OutW      = 11;
  localparam int InTdataW  = 16;
  localparam int OutTdataW = 40;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 3'd0,
    OP_PEEK  = 3'd1,
    OP_FREE  = 3'd2,
    OP_USED  = 3'd3,
    OP_MOD   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MODIFY,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic latch_in;
    logic decode;
    logic scan_next;
    logic scan_take;
    logic mark_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic find_op;
    logic mark_op;
    logic free_empty;
    logic word_hit;
  } sts_t;

  function automatic logic [OffBits-1:0] lowest_set(input logic [WordBits-1:0] w);
    logic [OffBits-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = OffBits'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ design/lowest_first_block_allocator_unit.sv @@
// An accepted item is latched, then decoded while a free-map word is read. In-range mark-free
// and mark-used then modify that word; allocate or peek with a non-empty free set scans 64-bit
// words up to the lowest free id (at most NumBlocks/64, rounded up); the rest skip both steps.
// The result loads into the output register once it is free; items are taken one at a time,
// s_axis_tready low until then, and the scan reads one map word per cycle. Reset: counters clear
// at once; a clearing pass then writes zero to every free-map word, s_axis_tready low until done.
module lowest_first_block_allocator_unit #(
  parameter int NumBlocks = lfba_pkg::NumBlocksDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] operation, [12:3] block_index
  input  logic [lfba_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [10:0] result_index, [21:11] free_count, [32:22] high_water_mark
  output logic [lfba_pkg::OutTdataW-1:0]    m_axis_tdata,
  // [0] status
  output logic                              m_axis_tuser
);

  localparam int OutW = lfba_pkg::OutW;
  localparam logic [OutW-1:0] NoneOut = OutW'(NumBlocks);

  lfba_pkg::cmd_t    cmd;
  lfba_pkg::sts_t    sts;
  logic [OutW-1:0]   res_idx, free_cnt, hw_cnt;
  logic              res_full;

  lfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfba_dpath #(
    .NumBlocks (NumBlocks)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_op_i    (s_axis_tdata[2:0]),
    .in_idx_i   (s_axis_tdata[12:3]),
    .res_idx_o  (res_idx),
    .res_full_o (res_full),
    .free_cnt_o (free_cnt),
    .hw_cnt_o   (hw_cnt)
  );

  assign m_axis_tdata = {7'b0, hw_cnt, free_cnt, res_idx};
  assign m_axis_tuser = res_full;

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[10:0] == NoneOut) && (m_axis_tdata[21:11] == '0) &&
      (m_axis_tdata[32:22] == NoneOut))
    else $error("full status with free ids or headroom left");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new item taken while one is in progress");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_we |-> !s_axis_tready && !cmd.out_load)
    else $error("item traffic during map clearing");

endmodule

@@ design/lfba_ctrl.sv @@
module lfba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lfba_pkg::sts_t  sts_i,
  output lfba_pkg::cmd_t  cmd_o
);

  lfba_pkg::state_e state_q, state_d;
  logic             out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfba_pkg::ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lfba_pkg::ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = lfba_pkg::ST_IDLE;
        end
      end
      lfba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = lfba_pkg::ST_DECODE;
        end
      end
      lfba_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.find_op && !sts_i.free_empty) begin
          state_d = lfba_pkg::ST_SCAN;
        end else if (sts_i.mark_op) begin
          state_d = lfba_pkg::ST_MODIFY;
        end else begin
          state_d = lfba_pkg::ST_RESP;
        end
      end
      lfba_pkg::ST_SCAN: begin
        if (sts_i.word_hit) begin
          cmd_o.scan_take = 1'b1;
          state_d         = lfba_pkg::ST_RESP;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      lfba_pkg::ST_MODIFY: begin
        cmd_o.mark_apply = 1'b1;
        state_d          = lfba_pkg::ST_RESP;
      end
      lfba_pkg::ST_RESP: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ design/lfba_dpath.sv @@
module lfba_dpath #(
  parameter int NumBlocks = lfba_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfba_pkg::cmd_t                cmd_i,
  output lfba_pkg::sts_t                sts_o,
  input  logic [lfba_pkg::OpW-1:0]      in_op_i,
  input  logic [lfba_pkg::InIdxW-1:0]   in_idx_i,
  output logic [lfba_pkg::OutW-1:0]     res_idx_o,
  output logic                          res_full_o,
  output logic [lfba_pkg::OutW-1:0]     free_cnt_o,
  output logic [lfba_pkg::OutW-1:0]     hw_cnt_o
);

  localparam int WordBits = lfba_pkg::WordBits;
  localparam int OffBits  = lfba_pkg::OffBits;
  localparam int OutW     = lfba_pkg::OutW;
  localparam int OpW      = lfba_pkg::OpW;
  localparam int NumWords = (NumBlocks + WordBits - 1) / WordBits;
  localparam int AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int IdxW     = $clog2(NumBlocks);
  localparam int CntW     = $clog2(NumBlocks + 1);
  localparam logic [CntW-1:0] NoneId = CntW'(NumBlocks);

  logic [WordBits-1:0] mem [NumWords];
  logic [WordBits-1:0] rdata_q;
  logic [AddrW-1:0]    chk_q;

  logic [OpW-1:0]      op_q;
  logic [IdxW-1:0]     idx_q;
  logic                idx_ok_q;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [CntW-1:0]     free_total_q, free_total_d;
  logic [CntW-1:0]     hw_q, hw_d;
  logic [CntW-1:0]     pend_idx_q;
  logic                pend_full_q;

  logic                find_op, mark_op, is_alloc;
  logic [AddrW-1:0]    idx_word;
  logic [OffBits-1:0]  idx_off, hit_off;
  logic [WordBits-1:0] idx_sel, hit_sel;
  logic                wr_en, rd_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [WordBits-1:0] wr_data;

  assign is_alloc = (op_q == lfba_pkg::OP_ALLOC);
  assign find_op  = is_alloc || (op_q == lfba_pkg::OP_PEEK);
  assign mark_op  = ((op_q == lfba_pkg::OP_FREE) || (op_q == lfba_pkg::OP_USED)) && idx_ok_q;
  assign idx_word = AddrW'(idx_q >> OffBits);
  assign idx_off  = OffBits'(idx_q);
  assign idx_sel  = WordBits'(1) << idx_off;
  assign hit_off  = lfba_pkg::lowest_set(rdata_q);
  assign hit_sel  = WordBits'(1) << hit_off;

  assign sts_o.clr_last   = (addr_q == AddrW'(NumWords - 1));
  assign sts_o.find_op    = find_op;
  assign sts_o.mark_op    = mark_op;
  assign sts_o.free_empty = (free_total_q == '0);
  assign sts_o.word_hit   = (rdata_q != '0);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = addr_q;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = addr_q;
    addr_d       = addr_q;
    free_total_d = free_total_q;
    hw_d         = hw_q;
    if (cmd_i.clr_we) begin
      wr_en  = 1'b1;
      addr_d = addr_q + AddrW'(1);
    end
    if (cmd_i.decode) begin
      rd_en   = 1'b1;
      rd_addr = find_op ? '0 : idx_word;
      addr_d  = AddrW'(1);
      if (find_op && (free_total_q == '0) && (hw_q != NoneId) && is_alloc) begin
        hw_d = hw_q + CntW'(1);
      end
    end
    if (cmd_i.scan_next) begin
      rd_en  = 1'b1;
      addr_d = addr_q + AddrW'(1);
    end
    if (cmd_i.scan_take && is_alloc) begin
      wr_en        = 1'b1;
      wr_addr      = chk_q;
      wr_data      = rdata_q & ~hit_sel;
      free_total_d = free_total_q - CntW'(1);
    end
    if (cmd_i.mark_apply) begin
      wr_addr = chk_q;
      if (op_q == lfba_pkg::OP_FREE) begin
        if ((rdata_q & idx_sel) == '0) begin
          wr_en        = 1'b1;
          wr_data      = rdata_q | idx_sel;
          free_total_d = free_total_q + CntW'(1);
        end
      end else if ((rdata_q & idx_sel) != '0) begin
        wr_en        = 1'b1;
        wr_data      = rdata_q & ~idx_sel;
        free_total_d = free_total_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      chk_q   <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      free_total_q <= '0;
      hw_q         <= '0;
    end else begin
      addr_q       <= addr_d;
      free_total_q <= free_total_d;
      hw_q         <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q        <= in_op_i;
      idx_q       <= IdxW'(in_idx_i);
      idx_ok_q    <= (32'(in_idx_i) < NumBlocks);
      pend_idx_q  <= NoneId;
      pend_full_q <= 1'b0;
    end
    if (cmd_i.decode && find_op && (free_total_q == '0)) begin
      if (hw_q != NoneId) begin
        pend_idx_q <= hw_q;
      end else begin
        pend_full_q <= 1'b1;
      end
    end
    if (cmd_i.scan_take) begin
      pend_idx_q <= CntW'({chk_q, hit_off});
    end
    if (cmd_i.out_load) begin
      res_idx_o  <= OutW'(pend_idx_q);
      res_full_o <= pend_full_q;
      free_cnt_o <= OutW'(free_total_q);
      hw_cnt_o   <= OutW'(hw_q);
    end
  end

endmodule
